// File: rtl/sdtq_pkg.sv
package sdtq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_RESULTS   = 16;
  localparam int ID_W          = 8;
  localparam int KIND_W        = 2;
  localparam int NCNT_W        = $clog2(MAX_RESULTS + 1);

  // request codes
  localparam logic REQ_ARM   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] EV_ARMED   = 2'd0;
  localparam logic [KIND_W-1:0] EV_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] EV_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] EV_NONE    = 2'd3;

endpackage

// File: rtl/sorted_deadline_timer_queue.sv
// An arm makes one backward pass over the held entries (one memory read and one
// write per cycle); a check pops due entries from the head, at most MAX_RESULTS per
// check, and gives a single none result when nothing is due.
// Throughput: one item at a time; the entry memory port pair sets the pace.
// Output stalls add cycles; the output register lets the next item in while a result waits.
// Reset (rst_n, synchronous, active low) empties the queue and clears the handshake;
// the entry memory is not cleared, only entries below the fill count are ever used.
module sorted_deadline_timer_queue #(
  parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [TIME_BITS-1:0]          in_now_tick,
  input  logic [TIME_BITS-1:0]          in_timeout_ticks,
  input  logic [sdtq_pkg::ID_W-1:0]     in_task_id,
  input  logic [sdtq_pkg::ID_W-1:0]     in_wait_queue_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdtq_pkg::KIND_W-1:0]   out_event_kind,
  output logic [sdtq_pkg::ID_W-1:0]     out_expired_task,
  output logic [sdtq_pkg::ID_W-1:0]     out_expired_queue,
  output logic                          out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index
  localparam int CW = $clog2(DEPTH + 1);                  // fill count
  localparam int IW = sdtq_pkg::ID_W;
  localparam int EW = TIME_BITS + 2 * IW;                 // {deadline, task, queue}
  localparam int NW = sdtq_pkg::NCNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ARM  = 5'b00010,   // backward scan: shift later deadlines up by one
    S_AWR  = 5'b00100,   // new entry goes to the head slot
    S_CHK  = 5'b01000,   // pop due entries from the head
    S_RESP = 5'b10000    // single closing result
  } state_t;

  // Ring of entries, kept sorted in logical order starting at head_r.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q_r;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;       // logical index being examined
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic [TIME_BITS-1:0]    key_r, key_nxt;       // deadline on arm, now on check
  logic [IW-1:0]           task_r, task_nxt;
  logic [IW-1:0]           queue_r, queue_nxt;
  logic [sdtq_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic                    pend_r, pend_nxt;     // an expiry waits for its last flag
  logic [2*IW-1:0]         pend_id_r, pend_id_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [sdtq_pkg::KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [IW-1:0]           out_task_r, out_task_nxt;
  logic [IW-1:0]           out_queue_r, out_queue_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [EW-1:0]           wr_data;

  logic                    in_fire;
  logic                    out_free;
  logic [TIME_BITS:0]      dl_sum;
  logic [TIME_BITS-1:0]    dl_sat;
  logic [TIME_BITS-1:0]    rd_dl;
  logic [CW-1:0]           count_m1;
  logic                    take;

  // Logical slot to physical address, one compare and subtract.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_ready          = (state_r == S_IDLE);
  assign in_fire           = in_valid && in_ready;
  assign out_free          = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_expired_task  = out_task_r;
  assign out_expired_queue = out_queue_r;
  assign out_last          = out_last_r;

  // Saturating deadline.
  assign dl_sum   = {1'b0, in_now_tick} + {1'b0, in_timeout_ticks};
  assign dl_sat   = dl_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dl_sum[TIME_BITS-1:0];
  assign rd_dl    = rd_q_r[EW-1 -: TIME_BITS];
  assign count_m1 = count_r - CW'(1);
  assign take     = (count_r != '0) && (rd_dl <= key_r) && (n_r < NW'(sdtq_pkg::MAX_RESULTS));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rd_addr_nxt   = rd_addr_r;
    key_nxt       = key_r;
    task_nxt      = task_r;
    queue_nxt     = queue_r;
    kind_nxt      = kind_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_task_nxt  = out_task_r;
    out_queue_nxt = out_queue_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = rd_addr_r;
    wr_data       = {key_r, task_r, queue_r};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          task_nxt  = in_task_id;
          queue_nxt = in_wait_queue_id;
          if (in_req_type == sdtq_pkg::REQ_ARM) begin
            key_nxt = dl_sat;
            if (count_r == CW'(DEPTH)) begin
              kind_nxt  = sdtq_pkg::EV_FULL;
              state_nxt = S_RESP;
            end else if (count_r == '0) begin
              state_nxt = S_AWR;
            end else begin
              idx_nxt     = count_m1[AW-1:0];
              rd_addr_nxt = phys(head_r, count_m1[AW-1:0]);
              state_nxt   = S_ARM;
            end
          end else begin
            key_nxt     = in_now_tick;
            n_nxt       = '0;
            pend_nxt    = 1'b0;
            rd_addr_nxt = head_r;
            state_nxt   = S_CHK;
          end
        end
      end

      S_ARM: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, idx_r + AW'(1));
        if (rd_dl > key_r) begin
          // later deadline moves up one slot
          wr_data = rd_q_r;
          if (idx_r == '0) begin
            state_nxt = S_AWR;
          end else begin
            idx_nxt     = idx_r - AW'(1);
            rd_addr_nxt = phys(head_r, idx_r - AW'(1));
          end
        end else begin
          count_nxt = count_r + CW'(1);
          kind_nxt  = sdtq_pkg::EV_ARMED;
          state_nxt = S_RESP;
        end
      end

      S_AWR: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        count_nxt = count_r + CW'(1);
        kind_nxt  = sdtq_pkg::EV_ARMED;
        state_nxt = S_RESP;
      end

      S_CHK: begin
        if (take) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = sdtq_pkg::EV_EXPIRED;
              {out_task_nxt, out_queue_nxt} = pend_id_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt    = 1'b1;
            pend_id_nxt = rd_q_r[2*IW-1:0];
            head_nxt    = phys(head_r, AW'(1));
            rd_addr_nxt = phys(head_r, AW'(1));
            count_nxt   = count_m1;
            n_nxt       = n_r + NW'(1);
          end
        end else if (pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sdtq_pkg::EV_EXPIRED;
            {out_task_nxt, out_queue_nxt} = pend_id_r;
            out_last_nxt  = 1'b1;
            pend_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else begin
          kind_nxt  = sdtq_pkg::EV_NONE;
          task_nxt  = '0;
          queue_nxt = '0;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_task_nxt  = task_r;
          out_queue_nxt = queue_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rd_addr_r   <= rd_addr_nxt;
    key_r       <= key_nxt;
    task_r      <= task_nxt;
    queue_r     <= queue_nxt;
    kind_r      <= kind_nxt;
    n_r         <= n_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_task_r  <= out_task_nxt;
    out_queue_r <= out_queue_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// File: sim/sorted_deadline_timer_queue_tb.sv
`timescale 1ns / 100ps

module sorted_deadline_timer_queue_tb;

  localparam int DEPTH = sdtq_pkg::DEPTH_DEF;
  localparam int TW    = sdtq_pkg::TIME_BITS_DEF;
  localparam int IDW   = sdtq_pkg::ID_W;
  localparam int KW    = sdtq_pkg::KIND_W;
  localparam logic [TW-1:0] TIME_MAX = '1;

  // One request item as the sender presents it. "tight" marks items that go
  // out with no idling on either side.
  typedef struct packed {
    logic            req;
    logic [TW-1:0]   now;
    logic [TW-1:0]   tmo;
    logic [IDW-1:0]  tid;
    logic [IDW-1:0]  tag;
    logic            tight;
  } timer_req_t;

  // One result item as it should leave the block.
  typedef struct packed {
    logic [KW-1:0]   kind;
    logic [IDW-1:0]  tid;
    logic [IDW-1:0]  tag;
    logic            last;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_req_type = sdtq_pkg::REQ_ARM;
  logic [TW-1:0]   in_now_tick = '0;
  logic [TW-1:0]   in_timeout_ticks = '0;
  logic [IDW-1:0]  in_task_id = '0;
  logic [IDW-1:0]  in_wait_queue_id = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KW-1:0]     out_event_kind;
  logic [IDW-1:0]    out_expired_task;
  logic [IDW-1:0]    out_expired_queue;
  logic              out_last;

  sorted_deadline_timer_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_now_tick       (in_now_tick),
    .in_timeout_ticks  (in_timeout_ticks),
    .in_task_id        (in_task_id),
    .in_wait_queue_id  (in_wait_queue_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_expired_task  (out_expired_task),
    .out_expired_queue (out_expired_queue),
    .out_last          (out_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timer_req_t   req_queue[$];       // items not yet offered
  timer_event_t pending_events[$];  // predicted results, oldest first

  // Shadow copy of the sorted timer list
  logic [TW-1:0]   dl_shadow [DEPTH];
  logic [IDW-1:0]  tid_shadow[DEPTH];
  logic [IDW-1:0]  tag_shadow[DEPTH];
  int              held_count = 0;

  int   errors = 0;
  int   results_seen = 0;
  logic in_taken = 1'b0;  // handshake seen at the last rising edge
  logic tight = 1'b0;     // current item runs with no idling

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted request to the shadow list and queues
  // the results it must cause.
  // --------------------------------------------------------------------------
  task automatic timer_queue_predict(input timer_req_t r);
    logic [TW:0]   sum;
    logic [TW-1:0] dl;
    int            pos;
    int            n;
    timer_event_t  ev;
    if (r.req == sdtq_pkg::REQ_ARM) begin
      // deadline saturates at the top of the time range
      sum = {1'b0, r.now} + {1'b0, r.tmo};
      dl  = sum[TW] ? TIME_MAX : sum[TW-1:0];
      ev  = '{kind: sdtq_pkg::EV_ARMED, tid: r.tid, tag: r.tag, last: 1'b1};
      if (held_count >= DEPTH) begin
        ev.kind = sdtq_pkg::EV_FULL;  // list unchanged
      end else begin
        // insert behind every entry due at or before the new one
        pos = 0;
        while (pos < held_count && dl_shadow[pos] <= dl) pos++;
        for (int i = held_count; i > pos; i--) begin
          dl_shadow[i]  = dl_shadow[i-1];
          tid_shadow[i] = tid_shadow[i-1];
          tag_shadow[i] = tag_shadow[i-1];
        end
        dl_shadow[pos]  = dl;
        tid_shadow[pos] = r.tid;
        tag_shadow[pos] = r.tag;
        held_count++;
      end
      pending_events.push_back(ev);
    end else begin
      // pop due entries from the head, at most MAX_RESULTS per check
      n = 0;
      while (n < sdtq_pkg::MAX_RESULTS && held_count > 0 && dl_shadow[0] <= r.now) begin
        ev = '{kind: sdtq_pkg::EV_EXPIRED, tid: tid_shadow[0], tag: tag_shadow[0],
               last: 1'b0};
        for (int i = 1; i < held_count; i++) begin
          dl_shadow[i-1]  = dl_shadow[i];
          tid_shadow[i-1] = tid_shadow[i];
          tag_shadow[i-1] = tag_shadow[i];
        end
        held_count--;
        n++;
        ev.last = !(n < sdtq_pkg::MAX_RESULTS && held_count > 0 && dl_shadow[0] <= r.now);
        pending_events.push_back(ev);
      end
      if (n == 0)
        pending_events.push_back('{kind: sdtq_pkg::EV_NONE, tid: '0, tag: '0, last: 1'b1});
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    timer_event_t got;
    timer_event_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        timer_queue_predict('{req: in_req_type, now: in_now_tick, tmo: in_timeout_ticks,
                              tid: in_task_id, tag: in_wait_queue_id, tight: 1'b0});
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{kind: out_event_kind, tid: out_expired_task,
                tag: out_expired_queue, last: out_last};
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0d task %0d queue %0d last %0d",
                   $time, got.kind, got.tid, got.tag, got.last);
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch, expected kind %0d task %0d queue %0d last %0d,",
                     $time, want.kind, want.tid, want.tag, want.last);
            $display("%0t:   actual kind %0d task %0d queue %0d last %0d",
                     $time, got.kind, got.tid, got.tag, got.last);
          end
        end
      end
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge only.
  // --------------------------------------------------------------------------
  int tx_gap = 0;
  always @(negedge clk) begin
    timer_req_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the item until accepted
    end else if (tx_gap > 0 && !tight) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (req_queue.size() != 0) begin
      it = req_queue.pop_front();
      in_valid         <= 1'b1;
      in_req_type      <= it.req;
      in_now_tick      <= it.now;
      in_timeout_ticks <= it.tmo;
      in_task_id       <= it.tid;
      in_wait_queue_id <= it.tag;
      tight            <= it.tight;
      tx_gap = it.tight ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off once results flow so the
  // block backs up and drops in_ready while the sender keeps offering.
  // --------------------------------------------------------------------------
  int rx_hold = 0;
  bit long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 40) begin
      long_hold_done = 1'b1;
      rx_hold = 300;
      out_ready <= 1'b0;
    end else if (tight || $urandom_range(0, 9) < 6) begin
      out_ready <= 1'b1;
    end else begin
      rx_hold = pick_gap();
      out_ready <= 1'b0;
    end
  end

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TW-1:0];
  endfunction

  task automatic push_req(input logic req, input logic [TW-1:0] now,
                          input logic [TW-1:0] tmo, input logic tgt);
    req_queue.push_back('{req: req, now: now, tmo: tmo, tid: IDW'($urandom),
                          tag: IDW'($urandom), tight: tgt});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [TW-1:0] clock_now;
    logic [TW-1:0] tmo;
    logic [TW-1:0] now;
    int            r;
    int            t;

    // directed: empty check, zero and max fields, saturation, equal deadlines
    req_queue.push_back('{req: sdtq_pkg::REQ_CHECK, now: '0, tmo: '0, tid: '0, tag: '0,
                          tight: 1'b0});
    req_queue.push_back('{req: sdtq_pkg::REQ_ARM, now: '0, tmo: '0, tid: '0, tag: '0,
                          tight: 1'b0});
    req_queue.push_back('{req: sdtq_pkg::REQ_ARM, now: TIME_MAX, tmo: TIME_MAX, tid: '1,
                          tag: '1, tight: 1'b0});
    push_req(sdtq_pkg::REQ_ARM, TIME_MAX, '0, 1'b0);
    push_req(sdtq_pkg::REQ_ARM, 48'd100, 48'd5, 1'b0);
    push_req(sdtq_pkg::REQ_ARM, 48'd100, 48'd5, 1'b0);
    push_req(sdtq_pkg::REQ_CHECK, 48'd104, rand_time(), 1'b0);
    push_req(sdtq_pkg::REQ_CHECK, 48'd105, rand_time(), 1'b0);
    push_req(sdtq_pkg::REQ_CHECK, TIME_MAX - 1, rand_time(), 1'b0);
    push_req(sdtq_pkg::REQ_CHECK, TIME_MAX, rand_time(), 1'b0);
    // fill to the brim, bounce two arms off the full list, then drain it
    // with one check that expires every entry
    for (int i = 0; i < DEPTH; i++)
      push_req(sdtq_pkg::REQ_ARM, 48'd1000, 48'($urandom_range(0, 3)), 1'b0);
    push_req(sdtq_pkg::REQ_ARM, 48'd1000, 48'd0, 1'b0);
    push_req(sdtq_pkg::REQ_ARM, 48'd2000, 48'd7, 1'b0);
    push_req(sdtq_pkg::REQ_CHECK, 48'd5000, '0, 1'b0);

    // random: mostly a rising clock with near deadlines, some far or
    // saturated ones that pile up until a wild or max-time check sweeps them
    clock_now = 48'd6000;
    for (int i = 0; i < 130; i++) begin
      clock_now = clock_now + 48'($urandom_range(0, 20));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        t = $urandom_range(0, 9);
        if (t < 6)      tmo = 48'($urandom_range(0, 60));
        else if (t < 7) tmo = '0;
        else if (t < 9) tmo = rand_time();
        else            tmo = TIME_MAX;
        now = ($urandom_range(0, 19) == 0) ? rand_time() : clock_now;
        push_req(sdtq_pkg::REQ_ARM, now, tmo, i >= 60 && i < 100);
      end else begin
        if (r < 90)      now = clock_now;
        else if (r < 96) now = rand_time();
        else             now = TIME_MAX;
        push_req(sdtq_pkg::REQ_CHECK, now, rand_time(), i >= 60 && i < 100);
      end
    end
    push_req(sdtq_pkg::REQ_CHECK, TIME_MAX, '0, 1'b0);

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // catch stray results
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
